// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, skipped while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `ASSERT_CLK(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ===== hdl/rpfw_pkg.sv =====
package rpfw_pkg;

    localparam int SCREEN_W    = 1024;
    localparam int SCREEN_H    = 768;
    localparam int FRAME_BYTES = (SCREEN_W / 2) * SCREEN_H;
    localparam int MEM_AW      = $clog2(FRAME_BYTES);

    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 4;
    localparam int ADDR_W    = 19;
    localparam int DATA_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Shared adder width: covers signed coordinates, the read address and
    // a framebuffer address compared against the store size.
    localparam int NEED_W  = $clog2(FRAME_BYTES + 1);
    localparam int WIDE_W  = (NEED_W > ADDR_W) ? NEED_W : ADDR_W;
    localparam int ALU_W   = ((WIDE_W > COORD_W + 1) ? WIDE_W : COORD_W + 1) + 1;

    localparam int ROW_B1 = SCREEN_W / 8;
    localparam int ROW_B4 = SCREEN_W / 2;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic MODE_1BPP = 1'b0;
    localparam logic MODE_4BPP = 1'b1;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CLIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_READ    = 2'd2;

    typedef struct packed {
        logic                       req_type;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [COLOR_W-1:0]         pixel_color;
        logic [ADDR_W-1:0]          read_addr;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   byte_addr;
        logic [DATA_W-1:0]   byte_data;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
    } alu_rsp_t;

endpackage

// ===== hdl/rotated_pixel_framebuffer_writer.sv =====
// Draw item: IDLE, CX, CY, NX, NY, MUL, ADD, ACHK, RMW, OUT, then back to IDLE.
// Read item: IDLE, RCHK, RDATA, OUT, then back to IDLE (RDATA skipped if out of range); one item at a time.
// Clipped draw: goes to OUT from CX (x off-screen), CY (y off-screen) or ACHK.
// The steps follow the sequence through the one shared adder; OUT holds while the output register is full.
// Reset (aresetn low, synchronous) clears config, then zeroes all 393216
// framebuffer bytes, one byte a cycle, with s_ready low.
module rotated_pixel_framebuffer_writer import rpfw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CX    = 4'd2;
    localparam logic [3:0] ST_CY    = 4'd3;
    localparam logic [3:0] ST_NX    = 4'd4;
    localparam logic [3:0] ST_NY    = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_ADD   = 4'd7;
    localparam logic [3:0] ST_ACHK  = 4'd8;
    localparam logic [3:0] ST_RMW   = 4'd9;
    localparam logic [3:0] ST_RCHK  = 4'd10;
    localparam logic [3:0] ST_RDATA = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    localparam logic [ALU_W-1:0] W_M1   = ALU_W'(SCREEN_W - 1);
    localparam logic [ALU_W-1:0] H_M1   = ALU_W'(SCREEN_H - 1);
    localparam logic [ALU_W-1:0] W_FULL = ALU_W'(SCREEN_W);
    localparam logic [ALU_W-1:0] H_FULL = ALU_W'(SCREEN_H);
    localparam logic [ALU_W-1:0] FB_SZ  = ALU_W'(FRAME_BYTES);
    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(FRAME_BYTES - 1);

    logic [3:0]        state_reg, state_next;
    logic [1:0]        rotation_reg;
    logic              display_mode_reg;
    logic [MEM_AW-1:0] clr_cnt_reg, clr_cnt_next;
    in_item_t          item_reg, item_next;
    logic [ALU_W-1:0]  nx_reg, nx_next;
    logic [ALU_W-1:0]  ny_reg, ny_next;
    logic [ALU_W-1:0]  acc_reg, acc_next;
    out_item_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    logic [ALU_W-1:0]  x_ext, y_ext, rd_ext;
    logic              rot_odd;

    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    logic [DATA_W-1:0] pix_mask, new_byte;

    rpfw_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    rpfw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FRAME_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign x_ext   = {{(ALU_W-COORD_W){item_reg.pos_x[COORD_W-1]}}, item_reg.pos_x};
    assign y_ext   = {{(ALU_W-COORD_W){item_reg.pos_y[COORD_W-1]}}, item_reg.pos_y};
    assign rd_ext  = ALU_W'(item_reg.read_addr);
    assign rot_odd = (rotation_reg == ROT_90) || (rotation_reg == ROT_270);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Operand selection for the shared adder.
    always_comb begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b1;
        unique case (state_reg)
            ST_CX: begin
                alu_req.a = x_ext;
                alu_req.b = rot_odd ? H_FULL : W_FULL;
            end
            ST_CY: begin
                alu_req.a = y_ext;
                alu_req.b = rot_odd ? W_FULL : H_FULL;
            end
            ST_NX: begin
                unique case (rotation_reg)
                    ROT_90:  begin alu_req.a = W_M1;  alu_req.b = y_ext; end
                    ROT_180: begin alu_req.a = W_M1;  alu_req.b = x_ext; end
                    ROT_270: begin alu_req.a = y_ext; alu_req.b = '0;    end
                    default: begin alu_req.a = x_ext; alu_req.b = '0;    end
                endcase
            end
            ST_NY: begin
                unique case (rotation_reg)
                    ROT_90:  begin alu_req.a = x_ext; alu_req.b = '0;    end
                    ROT_180: begin alu_req.a = H_M1;  alu_req.b = y_ext; end
                    ROT_270: begin alu_req.a = H_M1;  alu_req.b = x_ext; end
                    default: begin alu_req.a = y_ext; alu_req.b = '0;    end
                endcase
            end
            ST_ADD: begin
                alu_req.a   = acc_reg;
                alu_req.b   = (display_mode_reg == MODE_4BPP) ? (nx_reg >> 1) : (nx_reg >> 3);
                alu_req.sub = 1'b0;
            end
            ST_ACHK: begin
                alu_req.a = acc_reg;
                alu_req.b = FB_SZ;
            end
            ST_RCHK: begin
                alu_req.a = rd_ext;
                alu_req.b = FB_SZ;
            end
            default: begin
                alu_req.a = '0;
            end
        endcase
    end

    // Merge the new pixel into the fetched byte.
    always_comb begin
        pix_mask = DATA_W'(1) << nx_reg[2:0];
        if (display_mode_reg == MODE_4BPP) begin
            if (nx_reg[0]) begin
                new_byte = {item_reg.pixel_color, ram_rdata[3:0]};
            end else begin
                new_byte = {ram_rdata[7:4], item_reg.pixel_color};
            end
        end else begin
            new_byte = (ram_rdata & ~pix_mask) |
                       ((item_reg.pixel_color != '0) ? pix_mask : '0);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = acc_reg[MEM_AW-1:0];
        ram_wdata = new_byte;
        ram_raddr = acc_reg[MEM_AW-1:0];
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_RMW) begin
            ram_we = 1'b1;
        end
        if (state_reg == ST_RCHK) begin
            ram_raddr = MEM_AW'(item_reg.read_addr);
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        item_next    = item_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = (s_data.req_type == REQ_READ) ? ST_RCHK : ST_CX;
                end
            end
            ST_CX: begin
                res_next = '{byte_addr: '0, byte_data: '0, status: STATUS_CLIPPED};
                // drop negative or beyond-width x
                state_next = (item_reg.pos_x[COORD_W-1] || !alu_rsp.neg) ? ST_OUT : ST_CY;
            end
            ST_CY: begin
                state_next = (item_reg.pos_y[COORD_W-1] || !alu_rsp.neg) ? ST_OUT : ST_NX;
            end
            ST_NX: begin
                nx_next    = alu_rsp.sum;
                state_next = ST_NY;
            end
            ST_NY: begin
                ny_next    = alu_rsp.sum;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (display_mode_reg == MODE_4BPP) begin
                    acc_next = ALU_W'(ny_reg * ALU_W'(ROW_B4));
                end else begin
                    acc_next = ALU_W'(ny_reg * ALU_W'(ROW_B1));
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                acc_next   = alu_rsp.sum;
                state_next = ST_ACHK;
            end
            ST_ACHK: begin
                // in range: read issued this cycle, data arrives in ST_RMW
                state_next = alu_rsp.neg ? ST_RMW : ST_OUT;
            end
            ST_RMW: begin
                res_next   = '{byte_addr: acc_reg[ADDR_W-1:0], byte_data: new_byte,
                               status: STATUS_WRITTEN};
                state_next = ST_OUT;
            end
            ST_RCHK: begin
                res_next   = '{byte_addr: item_reg.read_addr, byte_data: '0,
                               status: STATUS_READ};
                state_next = alu_rsp.neg ? ST_RDATA : ST_OUT;
            end
            ST_RDATA: begin
                res_next.byte_data = ram_rdata;
                state_next         = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            m_valid_reg      <= 1'b0;
            rotation_reg     <= ROT_0;
            display_mode_reg <= MODE_1BPP;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                if (cfg_index == REG_ROTATION) begin
                    rotation_reg <= cfg_wdata[1:0];
                end else if (cfg_index == REG_DISPLAY_MODE) begin
                    display_mode_reg <= cfg_wdata[0];
                end
            end
        end
        item_reg   <= item_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hdl/rpfw_ram.sv =====
module rpfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/rpfw_alu.sv =====
module rpfw_alu import rpfw_pkg::*; (
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W-1:0] b_eff;

    assign b_eff   = req.sub ? ~req.b : req.b;
    assign rsp.sum = req.a + b_eff + ALU_W'(req.sub);
    assign rsp.neg = rsp.sum[ALU_W-1];

endmodule

// ===== hdl/rpfw_checker.sv =====
`include "assert_macros.svh"

module rpfw_checker import rpfw_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic clip_out;
    logic clip_zero;

    assign clip_out  = m_valid && (m_data.status == STATUS_CLIPPED);
    assign clip_zero = (m_data.byte_addr == '0) && (m_data.byte_data == '0);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `ASSERT_IMPLIES(a_status_code, aclk, aresetn, m_valid, m_data.status <= STATUS_READ)
    `ASSERT_IMPLIES(a_clip_zero, aclk, aresetn, clip_out, clip_zero)
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind rotated_pixel_framebuffer_writer rpfw_checker u_rpfw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/tb_rotated_pixel_framebuffer_writer.sv =====
`timescale 1ns / 100ps

module tb_rotated_pixel_framebuffer_writer;
    import rpfw_pkg::*;

    localparam int  PHASES       = 8;
    localparam int  ITEMS_PER_PH = 85;
    localparam int  HOLD_LEN     = 300;
    // Reset clears the whole store, byte by byte, before the first item is taken.
    localparam int  STUCK_LIMIT  = 4 * FRAME_BYTES;
    localparam int  SETTLE       = 12;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    rotated_pixel_framebuffer_writer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Shadow of the framebuffer and the active screen setup
    bit [7:0]   fb_shadow [FRAME_BYTES];
    logic [1:0] cur_rot  = ROT_0;
    logic       cur_mode = MODE_1BPP;

    in_item_t   pending_reqs[$];
    out_item_t  expected_bytes[$];

    int  fail_count    = 0;
    int  tx_gap        = 0;
    int  rx_stall      = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  stuck_cycles  = 0;
    bit  idle_on       = 1'b1;
    int  last_x        = 0;
    int  last_y        = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Native byte address of a logical pixel, or -1 when it falls off-screen
    function automatic int pixel_addr(int x, int y, output int nx);
        int lw, lh, ny, a;
        lw = (cur_rot == ROT_90 || cur_rot == ROT_270) ? SCREEN_H : SCREEN_W;
        lh = (cur_rot == ROT_90 || cur_rot == ROT_270) ? SCREEN_W : SCREEN_H;
        nx = 0;
        if (x < 0 || y < 0 || x >= lw || y >= lh)
            return -1;
        case (cur_rot)
            ROT_90: begin
                nx = SCREEN_W - 1 - y;
                ny = x;
            end
            ROT_180: begin
                nx = SCREEN_W - 1 - x;
                ny = SCREEN_H - 1 - y;
            end
            ROT_270: begin
                nx = y;
                ny = SCREEN_H - 1 - x;
            end
            default: begin
                nx = x;
                ny = y;
            end
        endcase
        if (cur_mode == MODE_1BPP)
            a = ROW_B1 * ny + nx / 8;
        else
            a = ROW_B4 * ny + nx / 2;
        if (a >= FRAME_BYTES)
            return -1;
        return a;
    endfunction

    // Apply one request to the shadow framebuffer and return the byte it reports
    function automatic out_item_t plot_pixel(in_item_t it);
        out_item_t r;
        int        a, nx;
        logic [7:0] oldv, newv, m;
        r = '0;
        if (it.req_type == REQ_READ) begin
            r.byte_addr = it.read_addr;
            r.byte_data = (it.read_addr < FRAME_BYTES) ? fb_shadow[it.read_addr] : 8'h00;
            r.status    = STATUS_READ;
            return r;
        end
        r.status = STATUS_CLIPPED;
        a = pixel_addr(int'(it.pos_x), int'(it.pos_y), nx);
        if (a < 0)
            return r;
        oldv = fb_shadow[MEM_AW'(a)];
        if (cur_mode == MODE_1BPP) begin
            m    = 8'h01 << (nx & 7);
            newv = (oldv & ~m) | ((it.pixel_color != '0) ? m : 8'h00);
        end else if ((nx & 1) == 0) begin
            newv = {oldv[7:4], it.pixel_color};
        end else begin
            newv = {it.pixel_color, oldv[3:0]};
        end
        fb_shadow[MEM_AW'(a)] = newv;
        r.byte_addr  = ADDR_W'(a);
        r.byte_data  = newv;
        r.status     = STATUS_WRITTEN;
        return r;
    endfunction

    function automatic in_item_t make_req();
        in_item_t it;
        int lw, lh, pick, x, y, nx, a;
        lw = (cur_rot == ROT_90 || cur_rot == ROT_270) ? SCREEN_H : SCREEN_W;
        lh = (cur_rot == ROT_90 || cur_rot == ROT_270) ? SCREEN_W : SCREEN_H;
        // Fields not used by the request type carry noise
        it.req_type    = REQ_DRAW;
        it.pos_x       = COORD_W'($urandom);
        it.pos_y       = COORD_W'($urandom);
        it.pixel_color = ($urandom_range(0, 3) == 0) ? '0 : COLOR_W'($urandom);
        it.read_addr   = ADDR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            if (pick < 35) begin
                // stay close to the last pixel so neighbors share a byte
                x = last_x + $urandom_range(0, 6) - 3;
                y = last_y + $urandom_range(0, 2) - 1;
                if (x < 0) x = 0;
                if (x > lw - 1) x = lw - 1;
                if (y < 0) y = 0;
                if (y > lh - 1) y = lh - 1;
            end else if (pick < 55) begin
                x = $urandom_range(0, lw - 1);
                y = $urandom_range(0, lh - 1);
            end else begin
                x = $urandom_range(0, 1) ? lw - 1 : 0;
                y = $urandom_range(0, 1) ? lh - 1 : 0;
            end
            last_x   = x;
            last_y   = y;
            it.pos_x = COORD_W'(x);
            it.pos_y = COORD_W'(y);
        end else if (pick < 72) begin
            case ($urandom_range(0, 4))
                0: it.pos_x = COORD_W'(lw + $urandom_range(0, 3));
                1: it.pos_y = COORD_W'(lh + $urandom_range(0, 3));
                2: it.pos_x = COORD_W'(-1 - int'($urandom_range(0, 3)));
                3: it.pos_y = COORD_W'(-1 - int'($urandom_range(0, 3)));
                default: ;
            endcase
        end else if (pick < 94) begin
            it.req_type = REQ_READ;
            a = pixel_addr(last_x, last_y, nx);
            if (a >= 0 && $urandom_range(0, 3) != 0)
                it.read_addr = ADDR_W'(a);
            else
                it.read_addr = ADDR_W'($urandom_range(0, FRAME_BYTES - 1));
        end else begin
            it.req_type = REQ_READ;
        end
        return it;
    endfunction

    task automatic push_draw(int x, int y, int color);
        in_item_t it;
        it             = make_req();
        it.req_type    = REQ_DRAW;
        it.pos_x       = COORD_W'(x);
        it.pos_y       = COORD_W'(y);
        it.pixel_color = COLOR_W'(color);
        pending_reqs.push_back(it);
    endtask

    task automatic push_read(int addr);
        in_item_t it;
        it           = make_req();
        it.req_type  = REQ_READ;
        it.read_addr = ADDR_W'(addr);
        pending_reqs.push_back(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_ROTATION)
            cur_rot = val[1:0];
        else
            cur_mode = val[0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_bytes.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Sender: hold the item until taken, then advance or idle for a burst
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  = 0;
        end else begin
            if (s_valid && s_ready)
                expected_bytes.push_back(plot_pixel(s_data));
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  = tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_data  <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        tx_gap = $urandom_range(1, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts plus one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall = 0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                rx_stall    = HOLD_LEN;
            end
            if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                m_ready  <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rx_stall = $urandom_range(0, 18);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result: byte_addr %0d byte_data 0x%02h status %0d",
                       m_data.byte_addr, m_data.byte_data, m_data.status);
                fail_count++;
            end else begin
                exp_item = expected_bytes.pop_front();
                if (m_data.byte_addr !== exp_item.byte_addr) begin
                    $error("byte_addr mismatch: expected %0d, actual %0d",
                           exp_item.byte_addr, m_data.byte_addr);
                    fail_count++;
                end
                if (m_data.byte_data !== exp_item.byte_data) begin
                    $error("byte_data mismatch: expected 0x%02h, actual 0x%02h",
                           exp_item.byte_data, m_data.byte_data);
                    fail_count++;
                end
                if (m_data.status !== exp_item.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_item.status, m_data.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0] rot_seq  [PHASES];
        logic       mode_seq [PHASES];
        rot_seq  = '{ROT_0, ROT_90, ROT_180, ROT_270, ROT_270, ROT_0, ROT_90, ROT_180};
        mode_seq = '{MODE_1BPP, MODE_1BPP, MODE_4BPP, MODE_4BPP,
                     MODE_1BPP, MODE_4BPP, MODE_4BPP, MODE_1BPP};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                write_reg(REG_ROTATION, rot_seq[p]);
                write_reg(REG_DISPLAY_MODE, CFG_W'(mode_seq[p]));
            end
            if (p == 0) begin
                // corners, bit packing within one byte, clipping on every edge
                push_draw(0, 0, 15);
                push_draw(1, 0, 1);
                push_draw(7, 0, 9);
                push_read(0);
                push_draw(SCREEN_W - 1, SCREEN_H - 1, 1);
                push_read(ROW_B1 * SCREEN_H - 1);
                push_draw(SCREEN_W - 1, SCREEN_H - 1, 0);
                push_read(ROW_B1 * SCREEN_H - 1);
                push_draw(8, 1, 0);
                push_draw(-1, 0, 5);
                push_draw(0, -1, 5);
                push_draw(SCREEN_W, 0, 5);
                push_draw(0, SCREEN_H, 5);
                push_draw(-32768, -32768, 15);
                push_draw(32767, 32767, 15);
                push_draw(32767, 0, 3);
                push_read(1);
                push_read(FRAME_BYTES - 1);
                push_read(FRAME_BYTES);
                push_read((1 << ADDR_W) - 1);
            end
            if (p == PHASES - 1)
                idle_on = 1'b0;
            repeat (ITEMS_PER_PH) pending_reqs.push_back(make_req());
            if (p == 1) begin
                // hold the output once traffic flows so the input backs up
                do @(negedge aclk);
                while (expected_bytes.size() == 0);
                hold_requests++;
            end
        end

        wait_drained();
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
